FILE: src/tsf_pkg.sv
package tsf_pkg;

    localparam int DEF_MAX_LENGTH  = 256;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_MAX_TRACE   = 16384;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_LENGTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RISE_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_INDEX   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_INDEX    = 3'd4;

    localparam int RST_FILTER_LENGTH = 16;
    localparam int RST_RISE_LENGTH   = 6;
    localparam int RST_GAP_LENGTH    = 4;
    localparam int RST_START_INDEX   = 0;

endpackage

FILE: src/tsf_cfg.sv
module tsf_cfg
    import tsf_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH,
    parameter int MAX_TRACE  = DEF_MAX_TRACE
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]                i_cfg_index,
    input  logic [((($clog2(MAX_TRACE)+1) > ($clog2(MAX_LENGTH)+1)) ?
                   ($clog2(MAX_TRACE)+1) : ($clog2(MAX_LENGTH)+1))-1:0] i_cfg_data,
    output logic [$clog2(MAX_LENGTH):0]            o_len,
    output logic [$clog2(MAX_LENGTH):0]            o_rise,
    output logic [$clog2(MAX_LENGTH):0]            o_gap,
    output logic [((($clog2(MAX_TRACE)+1) > ($clog2(MAX_LENGTH)+1)) ?
                   ($clog2(MAX_TRACE)+1) : ($clog2(MAX_LENGTH)+1))-1:0] o_start,
    output logic [$clog2(MAX_TRACE):0]             o_stop
);

    localparam int ADDR_BITS = $clog2(MAX_LENGTH);
    localparam int LEN_BITS  = ADDR_BITS + 1;
    localparam int IDX_BITS  = $clog2(MAX_TRACE);
    localparam int CNT_BITS  = IDX_BITS + 1;
    localparam int CMP_BITS  = (CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS;

    logic [LEN_BITS-1:0]  r_len;
    logic [LEN_BITS-1:0]  r_rise;
    logic [ADDR_BITS-1:0] r_gap;
    logic [IDX_BITS-1:0]  r_start;
    logic [CNT_BITS-1:0]  r_stop;

    logic [LEN_BITS-1:0]  len;
    logic [LEN_BITS-1:0]  rise;
    logic [LEN_BITS-1:0]  room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_BITS'(RST_FILTER_LENGTH);
            r_rise  <= LEN_BITS'(RST_RISE_LENGTH);
            r_gap   <= ADDR_BITS'(RST_GAP_LENGTH);
            r_start <= IDX_BITS'(RST_START_INDEX);
            r_stop  <= CNT_BITS'(MAX_TRACE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FILTER_LENGTH: r_len   <= i_cfg_data[LEN_BITS-1:0];
                REG_RISE_LENGTH:   r_rise  <= i_cfg_data[LEN_BITS-1:0];
                REG_GAP_LENGTH:    r_gap   <= i_cfg_data[ADDR_BITS-1:0];
                REG_START_INDEX:   r_start <= i_cfg_data[IDX_BITS-1:0];
                REG_STOP_INDEX:    r_stop  <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_len == '0) begin
            len = LEN_BITS'(1);
        end else if (r_len > LEN_BITS'(MAX_LENGTH)) begin
            len = LEN_BITS'(MAX_LENGTH);
        end else begin
            len = r_len;
        end

        if (r_rise == '0) begin
            rise = LEN_BITS'(1);
        end else if (r_rise > len) begin
            rise = len;
        end else begin
            rise = r_rise;
        end

        room = len - rise;

        if (LEN_BITS'(r_gap) > room) begin
            o_gap = room;
        end else begin
            o_gap = LEN_BITS'(r_gap);
        end

        if (CMP_BITS'(r_start) < CMP_BITS'(len)) begin
            o_start = CMP_BITS'(len);
        end else begin
            o_start = CMP_BITS'(r_start);
        end
    end

    assign o_len  = len;
    assign o_rise = rise;
    assign o_stop = r_stop;

endmodule

FILE: src/trapezoidal_shaping_filter_unit.sv
// Trapezoidal shaping filter: takes one ADC sample per clock when ready and,
// for sample index i, returns the sum of the rise_length samples before i
// minus the sum of the earlier window starting at i-filter_length, with a
// sample index. Running prefix sums of the trace sit in two ring memories
// with registered reads, written as each transaction is accepted; each
// window is the difference of two stored prefix sums, so configuration
// changes between samples take effect immediately. Throughput is one sample
// per clock; an accepted sample fills stage one, then the output register,
// and the input stalls while both are full and i_ready is low. Indices
// below max(start_index, filter_length) return zero; indices at or beyond
// stop_index or MAX_TRACE return no result. No clearing pass.
module trapezoidal_shaping_filter_unit
    import tsf_pkg::*;
#(
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_TRACE   = DEF_MAX_TRACE
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,

    input  logic                                            i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]                         i_cfg_index,
    input  logic [((($clog2(MAX_TRACE)+1) > ($clog2(MAX_LENGTH)+1)) ?
                   ($clog2(MAX_TRACE)+1) : ($clog2(MAX_LENGTH)+1))-1:0] i_cfg_data,

    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [SAMPLE_BITS-1:0]                          i_sample,
    input  logic                                            i_first,

    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic signed [SAMPLE_BITS+$clog2(MAX_LENGTH):0]  o_filter_value,
    output logic [$clog2(MAX_TRACE)-1:0]                    o_sample_index
);

    localparam int ADDR_BITS = $clog2(MAX_LENGTH);
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int LEN_BITS  = ADDR_BITS + 1;
    localparam int IDX_BITS  = $clog2(MAX_TRACE);
    localparam int CNT_BITS  = IDX_BITS + 1;
    localparam int CMP_BITS  = (CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + ADDR_BITS + 1;

    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] rise;
    logic [LEN_BITS-1:0] gap;
    logic [CMP_BITS-1:0] start;
    logic [CNT_BITS-1:0] stop;

    tsf_cfg #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_TRACE  (MAX_TRACE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_len       (len),
        .o_rise      (rise),
        .o_gap       (gap),
        .o_start     (start),
        .o_stop      (stop)
    );

    logic [SUM_BITS-1:0] mem_a [DEPTH];
    logic [SUM_BITS-1:0] mem_b [DEPTH];

    logic [CNT_BITS-1:0] r_idx;
    logic [SUM_BITS-1:0] r_psum;

    logic                r_s1_valid;
    logic                r_s1_zero;
    logic [IDX_BITS-1:0] r_s1_idx;
    logic [SUM_BITS-1:0] r_s1_psum;
    logic [SUM_BITS-1:0] r_rd_rise;
    logic [SUM_BITS-1:0] r_rd_flat;
    logic [SUM_BITS-1:0] r_rd_len;

    logic                r_o_valid;
    logic [SUM_BITS-1:0] r_o_value;
    logic [IDX_BITS-1:0] r_o_idx;

    logic                 accept;
    logic                 s1_adv;
    logic [CNT_BITS-1:0]  cur_idx;
    logic [SUM_BITS-1:0]  cur_psum;
    logic                 emit;
    logic                 zero;
    logic [ADDR_BITS-1:0] a_cur;
    logic [ADDR_BITS-1:0] a_rise;
    logic [ADDR_BITS-1:0] a_flat;
    logic [ADDR_BITS-1:0] a_len;
    logic [CNT_BITS-1:0]  n_idx;
    logic [SUM_BITS-1:0]  n_value;

    assign s1_adv  = !r_o_valid || i_ready;
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    assign cur_idx  = i_first ? '0 : r_idx;
    assign cur_psum = i_first ? '0 : r_psum;
    assign emit     = (cur_idx < CNT_BITS'(MAX_TRACE)) && (cur_idx < stop);
    assign zero     = CMP_BITS'(cur_idx) < start;

    assign a_cur  = cur_idx[ADDR_BITS-1:0];
    assign a_rise = a_cur - rise[ADDR_BITS-1:0];
    assign a_flat = a_rise - gap[ADDR_BITS-1:0];
    assign a_len  = a_cur - len[ADDR_BITS-1:0];

    assign n_idx = (cur_idx < CNT_BITS'(MAX_TRACE)) ? cur_idx + CNT_BITS'(1) : cur_idx;

    // recent = P[i] - P[i-rise], early = P[i-rise-gap] - P[i-len]
    assign n_value = r_s1_zero ? '0 : (r_s1_psum - r_rd_rise) - (r_rd_flat - r_rd_len);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_a[a_cur] <= cur_psum;
            r_rd_rise    <= mem_a[a_rise];
            r_rd_flat    <= mem_a[a_flat];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_b[a_cur] <= cur_psum;
            r_rd_len     <= mem_b[a_len];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_psum     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_idx      <= n_idx;
                r_psum     <= cur_psum + SUM_BITS'(i_sample);
                r_s1_valid <= emit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_zero <= zero;
            r_s1_idx  <= cur_idx[IDX_BITS-1:0];
            r_s1_psum <= cur_psum;
        end
        if (s1_adv && r_s1_valid) begin
            r_o_value <= n_value;
            r_o_idx   <= r_s1_idx;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_filter_value = $signed(r_o_value);
    assign o_sample_index = r_o_idx;

endmodule
